### sv/max_heap_priority_queue_assert.svh
// assertion macros for the max-heap priority queue
`ifndef MAX_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define MAX_HEAP_PRIORITY_QUEUE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define MHPQ_ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MHPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/mhpq_pkg.sv
// shared types and constants of the max-heap priority queue
`timescale 1ns / 1ps

package mhpq_pkg;

   localparam int unsigned DATA_W  = 32;
   localparam int unsigned COUNT_W = 5;

   // operation codes of a request word
   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_DELETE = 1'b1
   } op_type;

   // status codes of a response word
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_UNDERFLOW = 2'd2
   } status_type;

   // top value reported for an empty heap
   localparam logic signed [DATA_W-1:0] TOP_EMPTY = -32'sd1;

   // one finished response word
   typedef struct packed {
      status_type                 status;
      logic signed [DATA_W-1:0]   removed_value;
      logic signed [DATA_W-1:0]   top_value;
      logic        [COUNT_W-1:0]  count;
   } result_type;

endpackage

### sv/mhpq_store.sv
// heap storage: synchronous memory, one write port and two registered read ports
`timescale 1ns / 1ps

module mhpq_store #(
   parameter int unsigned DEPTH = 16,
   parameter int unsigned AW    = 4
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [AW-1:0]                        wr_addr,
   input  logic signed [mhpq_pkg::DATA_W-1:0]   wr_data,
   input  logic [AW-1:0]                        rd_addr_a,
   input  logic [AW-1:0]                        rd_addr_b,
   output logic signed [mhpq_pkg::DATA_W-1:0]   rd_data_a,
   output logic signed [mhpq_pkg::DATA_W-1:0]   rd_data_b
);

   logic signed [mhpq_pkg::DATA_W-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read ports, registered
   always_ff @(posedge clock) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

### sv/mhpq_ctrl.sv
// heap sequencer: insert with sift-up, delete-max with sift-down, hole method
`timescale 1ns / 1ps

module mhpq_ctrl #(
   parameter int unsigned DEPTH = 16,
   parameter int unsigned AW    = 4,
   parameter int unsigned CW    = 5
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_operation,
   input  logic signed [mhpq_pkg::DATA_W-1:0]   req_value,
   output logic                                 res_valid,
   input  logic                                 res_ready,
   output mhpq_pkg::result_type                 res_word,
   output logic                                 mem_we,
   output logic [AW-1:0]                        mem_waddr,
   output logic signed [mhpq_pkg::DATA_W-1:0]   mem_wdata,
   output logic [AW-1:0]                        mem_raddr_a,
   output logic [AW-1:0]                        mem_raddr_b,
   input  logic signed [mhpq_pkg::DATA_W-1:0]   mem_rdata_a,
   input  logic signed [mhpq_pkg::DATA_W-1:0]   mem_rdata_b
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LAST,
      ST_DN_RD,
      ST_DN_CMP,
      ST_UP_RD,
      ST_UP_CMP,
      ST_RESP
   } state_type;

   state_type                           state_ff, state_in;
   logic [CW-1:0]                       count_ff, count_in;
   logic [AW-1:0]                       pos_ff, pos_in;
   logic signed [mhpq_pkg::DATA_W-1:0]  v_ff, v_in;
   logic signed [mhpq_pkg::DATA_W-1:0]  top_ff, top_in;
   mhpq_pkg::status_type                status_ff, status_in;
   logic signed [mhpq_pkg::DATA_W-1:0]  removed_ff, removed_in;

   logic                                full, empty;
   logic [CW-1:0]                       last_idx;
   logic [AW-1:0]                       parent;
   logic [AW+1:0]                       child_l, child_r, count_wide;
   logic                                left_ok, right_ok;
   logic                                pick_l, pick_r;
   logic signed [mhpq_pkg::DATA_W-1:0]  best_lv;
   logic [CW+4:0]                       count_ext;

   // index arithmetic around the current hole
   assign full       = (count_ff == CW'(DEPTH));
   assign empty      = (count_ff == '0);
   assign last_idx   = count_ff - 1'b1;
   assign parent     = (pos_ff - 1'b1) >> 1;
   assign child_l    = {1'b0, pos_ff, 1'b1};
   assign child_r    = child_l + 1'b1;
   assign count_wide = (AW+2)'(count_ff);
   assign left_ok    = (child_l < count_wide);
   assign right_ok   = (child_r < count_wide);

   // child selection: left if strictly above the moving value, right if above that
   assign pick_l  = left_ok && (mem_rdata_a > v_ff);
   assign best_lv = pick_l ? mem_rdata_a : v_ff;
   assign pick_r  = right_ok && (mem_rdata_b > best_lv);

   assign req_ready = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_RESP) && res_ready;

   // response word
   assign count_ext              = (CW+5)'(count_ff);
   assign res_word.status        = status_ff;
   assign res_word.removed_value = removed_ff;
   assign res_word.top_value     = empty ? mhpq_pkg::TOP_EMPTY : top_ff;
   assign res_word.count         = count_ext[mhpq_pkg::COUNT_W-1:0];

   // next state and memory commands
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      pos_in      = pos_ff;
      v_in        = v_ff;
      status_in   = status_ff;
      removed_in  = removed_ff;
      mem_we      = 1'b0;
      mem_waddr   = pos_ff;
      mem_wdata   = v_ff;
      mem_raddr_a = '0;
      mem_raddr_b = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               removed_in = '0;
               if (req_operation == mhpq_pkg::OP_INSERT) begin
                  if (full) begin
                     status_in = mhpq_pkg::STATUS_OVERFLOW;
                     state_in  = ST_RESP;
                  end else begin
                     status_in = mhpq_pkg::STATUS_OK;
                     v_in      = req_value;
                     pos_in    = count_ff[AW-1:0];
                     count_in  = count_ff + 1'b1;
                     state_in  = ST_UP_RD;
                  end
               end else begin
                  if (empty) begin
                     status_in = mhpq_pkg::STATUS_UNDERFLOW;
                     state_in  = ST_RESP;
                  end else begin
                     status_in   = mhpq_pkg::STATUS_OK;
                     removed_in  = top_ff;
                     count_in    = last_idx;
                     pos_in      = '0;
                     mem_raddr_a = last_idx[AW-1:0];
                     state_in    = ST_LAST;
                  end
               end
            end
         end
         ST_LAST: begin
            v_in     = mem_rdata_a;
            state_in = ST_DN_RD;
         end
         ST_DN_RD: begin
            if (left_ok) begin
               mem_raddr_a = child_l[AW-1:0];
               mem_raddr_b = right_ok ? child_r[AW-1:0] : child_l[AW-1:0];
               state_in    = ST_DN_CMP;
            end else begin
               mem_we   = 1'b1;
               state_in = ST_RESP;
            end
         end
         ST_DN_CMP: begin
            mem_we = 1'b1;
            if (pick_r) begin
               mem_wdata = mem_rdata_b;
               pos_in    = child_r[AW-1:0];
               state_in  = ST_DN_RD;
            end else if (pick_l) begin
               mem_wdata = mem_rdata_a;
               pos_in    = child_l[AW-1:0];
               state_in  = ST_DN_RD;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_UP_RD: begin
            if (pos_ff == '0) begin
               mem_we   = 1'b1;
               state_in = ST_RESP;
            end else begin
               mem_raddr_a = parent;
               state_in    = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            mem_we = 1'b1;
            if (v_ff > mem_rdata_a) begin
               mem_wdata = mem_rdata_a;
               pos_in    = parent;
               state_in  = ST_UP_RD;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // cached root tracks every write to the root entry
   always_comb begin
      top_in = top_ff;
      if (mem_we && (mem_waddr == '0)) begin
         top_in = mem_wdata;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      pos_ff     <= pos_in;
      v_ff       <= v_in;
      top_ff     <= top_in;
      status_ff  <= status_in;
      removed_ff <= removed_in;
   end

endmodule

### sv/max_heap_priority_queue.sv
// top level of the bounded max-heap priority queue with a response register
// insert: accept, then a read-compare step (UP_RD, UP_CMP) per level moved up, then RESP
// delete-max: accept, LAST fetch, then a read-compare step (DN_RD, DN_CMP) per level moved down, then RESP
// overflow or underflow go straight to RESP; one operation is in flight at a time
// one read-compare step per level on the single-write-port memory sets the rate
// reset clears the element count, sequencer state and response valid; storage stays unwritten, no clearing pass
`timescale 1ns / 1ps
`include "max_heap_priority_queue_assert.svh"

module max_heap_priority_queue #(
   parameter int unsigned HEAP_DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_operation,
   input  logic signed [mhpq_pkg::DATA_W-1:0]    req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [1:0]                            rsp_status,
   output logic signed [mhpq_pkg::DATA_W-1:0]    rsp_removed_value,
   output logic signed [mhpq_pkg::DATA_W-1:0]    rsp_top_value,
   output logic [mhpq_pkg::COUNT_W-1:0]          rsp_count
);

   localparam int unsigned AW = $clog2(HEAP_DEPTH);
   localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);

   logic                                 res_valid, res_ready;
   mhpq_pkg::result_type                 res_word;
   logic                                 mem_we;
   logic [AW-1:0]                        mem_waddr, mem_raddr_a, mem_raddr_b;
   logic signed [mhpq_pkg::DATA_W-1:0]   mem_wdata, mem_rdata_a, mem_rdata_b;

   logic                                 rsp_valid_ff, rsp_valid_in;
   mhpq_pkg::result_type                 rsp_word_ff;

   mhpq_store #(
      .DEPTH (HEAP_DEPTH),
      .AW    (AW)
   ) u_store (
      .clock     (clock),
      .wr_en     (mem_we),
      .wr_addr   (mem_waddr),
      .wr_data   (mem_wdata),
      .rd_addr_a (mem_raddr_a),
      .rd_addr_b (mem_raddr_b),
      .rd_data_a (mem_rdata_a),
      .rd_data_b (mem_rdata_b)
   );

   mhpq_ctrl #(
      .DEPTH (HEAP_DEPTH),
      .AW    (AW),
      .CW    (CW)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_value     (req_value),
      .res_valid     (res_valid),
      .res_ready     (res_ready),
      .res_word      (res_word),
      .mem_we        (mem_we),
      .mem_waddr     (mem_waddr),
      .mem_wdata     (mem_wdata),
      .mem_raddr_a   (mem_raddr_a),
      .mem_raddr_b   (mem_raddr_b),
      .mem_rdata_a   (mem_rdata_a),
      .mem_rdata_b   (mem_rdata_b)
   );

   // response register is free when empty or being drained
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (res_valid) begin
         rsp_word_ff <= res_word;
      end
   end

   // response word ports
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_word_ff.status;
   assign rsp_removed_value = rsp_word_ff.removed_value;
   assign rsp_top_value     = rsp_word_ff.top_value;
   assign rsp_count         = rsp_word_ff.count;

   // checks
   `MHPQ_ASSERT_HOLDS(a_load_only_when_free, clock, reset, res_valid,
      !rsp_valid_ff || rsp_ready, "response register overwritten while full")
   `MHPQ_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready,
      !req_ready, "request accepted while an operation is in flight")
   `MHPQ_ASSERT_HOLDS(a_underflow_word, clock, reset,
      rsp_valid && rsp_status == mhpq_pkg::STATUS_UNDERFLOW,
      rsp_removed_value == '0 && rsp_top_value == mhpq_pkg::TOP_EMPTY && rsp_count == '0,
      "underflow word carries stale data")

endmodule
